// ----- src/rhks_pkg.sv -----
// Package: constants, types and codes for the Robin Hood key set insert block.
`default_nettype none
package rhks_pkg;

  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = 11;
  localparam int unsigned DIST_W = 8;
  localparam int unsigned HASH_W = 64;
  localparam int unsigned LEN_W = 32;

  localparam logic [DIST_W-1:0] DIST_EMPTY = 8'hFF;
  localparam int unsigned LOAD_NUM = 85;
  localparam int unsigned LOAD_DEN = 100;
  localparam int unsigned LIMIT_RAW = (SLOTS * LOAD_NUM) / LOAD_DEN;
  localparam int unsigned LIMIT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned LIMIT_CLIP = (LIMIT_RAW == 0) ? 1 :
                                       (LIMIT_RAW > LIMIT_MAX) ? LIMIT_MAX : LIMIT_RAW;
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(LIMIT_CLIP);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  localparam int unsigned CMD_INSERT = 0;
  localparam int unsigned CMD_CLEAR = 1;

  localparam logic REG_LOAD_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_CLEARED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  typedef enum logic [1:0] {
    ACT_EMPTY,
    ACT_MATCH,
    ACT_SWAP,
    ACT_ADVANCE
  } act_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] hops;
  } slot_t;

  typedef struct packed {
    act_t              act;
    logic              stop_full;
    logic [DIST_W-1:0] hops_next;
  } probe_t;

endpackage
`default_nettype wire

// ----- src/robin_hood_key_set_insert.sv -----
// Top level: Robin Hood key set with probe sequencer, slot RAM and APB register.
// An insert walks the probe chain twice: a read-only pass
// decides the outcome, and only an insert that succeeds walks again writing
// the swaps, so a full or duplicate result leaves the table untouched. Each
// probed slot is read and then evaluated through the single slot RAM port pair;
// a full result from the load limit is given from idle without a probe walk.
// After reset and for each clear the block sweeps all 1024 slots, one per
// cycle, with busy high.
// Each result is a one-cycle done pulse with status and entry_total; it
// cannot be held off. load_limit may be written at any time.
`default_nettype none
module robin_hood_key_set_insert import rhks_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd,
  input  wire logic [HASH_W-1:0] key_hash,
  input  wire logic [LEN_W-1:0]  key_length,
  output logic                   done,
  output logic [1:0]             status,
  output logic [CNT_W-1:0]       entry_total,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  sweep_addr, sweep_addr_next;
  logic              sweep_clear, sweep_clear_next;
  logic              pass2, pass2_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [DIST_W-1:0] hops, hops_next;
  logic [HASH_W-1:0] ch, ch_next;
  logic [LEN_W-1:0]  cl, cl_next;
  logic [CNT_W-1:0]  steps, steps_next;
  logic [HASH_W-1:0] key_hash_r, key_hash_r_next;
  logic [LEN_W-1:0]  key_length_r, key_length_r_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  load_limit;
  logic [CNT_W-1:0]  limit_eff;
  logic              done_next;
  status_t           status_r, status_next;
  logic [CNT_W-1:0]  total_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  slot_t             ram_rdata;
  probe_t            pr;

  rhks_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  rhks_probe u_probe (
    .rd        (ram_rdata),
    .walk_hash (ch),
    .walk_len  (cl),
    .walk_hops (hops),
    .steps     (steps),
    .res       (pr)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOAD_LIMIT) ? {{(32-CNT_W){1'b0}}, load_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LOAD_LIMIT) begin
      load_limit <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    limit_eff = load_limit;
    if (load_limit == '0) limit_eff = CNT_W'(1);
    if (load_limit > SLOTS_CNT) limit_eff = SLOTS_CNT;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep_addr <= '0;
      sweep_clear <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      sweep_addr <= sweep_addr_next;
      sweep_clear <= sweep_clear_next;
      count <= count_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pass2 <= pass2_next;
    idx <= idx_next;
    hops <= hops_next;
    ch <= ch_next;
    cl <= cl_next;
    steps <= steps_next;
    key_hash_r <= key_hash_r_next;
    key_length_r <= key_length_r_next;
    status_r <= status_next;
    entry_total <= total_next;
  end

  assign status = status_r;

  always_comb begin
    state_next = state;
    sweep_addr_next = sweep_addr;
    sweep_clear_next = sweep_clear;
    pass2_next = pass2;
    idx_next = idx;
    hops_next = hops;
    ch_next = ch;
    cl_next = cl;
    steps_next = steps;
    key_hash_r_next = key_hash_r;
    key_length_r_next = key_length_r;
    count_next = count;
    done_next = 1'b0;
    status_next = status_r;
    total_next = entry_total;
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = '{hash: ch, len: cl, hops: hops};
    unique case (state)
      S_SWEEP: begin
        ram_we = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = '{hash: '0, len: '0, hops: DIST_EMPTY};
        sweep_addr_next = sweep_addr + IDX_W'(1);
        if (sweep_addr == IDX_W'(SLOTS - 1)) begin
          state_next = S_IDLE;
          count_next = '0;
          if (sweep_clear) begin
            done_next = 1'b1;
            status_next = ST_CLEARED;
            total_next = '0;
          end
          sweep_clear_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (cmd == 1'(CMD_CLEAR)) begin
            state_next = S_SWEEP;
            sweep_addr_next = '0;
            sweep_clear_next = 1'b1;
          end else if (count >= limit_eff) begin
            done_next = 1'b1;
            status_next = ST_FULL;
            total_next = count;
          end else begin
            state_next = S_READ;
            pass2_next = 1'b0;
            idx_next = key_hash[IDX_W-1:0];
            hops_next = '0;
            ch_next = key_hash;
            cl_next = key_length;
            steps_next = '0;
            key_hash_r_next = key_hash;
            key_length_r_next = key_length;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_READ;
        unique case (pr.act)
          ACT_EMPTY: begin
            if (!pass2) begin
              pass2_next = 1'b1;
              idx_next = key_hash_r[IDX_W-1:0];
              hops_next = '0;
              ch_next = key_hash_r;
              cl_next = key_length_r;
              steps_next = '0;
            end else begin
              ram_we = 1'b1;
              count_next = count + CNT_W'(1);
              state_next = S_IDLE;
              done_next = 1'b1;
              status_next = ST_INSERTED;
              total_next = count + CNT_W'(1);
            end
          end
          ACT_MATCH: begin
            state_next = S_IDLE;
            done_next = 1'b1;
            status_next = ST_DUPLICATE;
            total_next = count;
          end
          ACT_SWAP, ACT_ADVANCE: begin
            if (pr.act == ACT_SWAP) begin
              ram_we = pass2;
              ch_next = ram_rdata.hash;
              cl_next = ram_rdata.len;
            end
            hops_next = pr.hops_next;
            idx_next = idx + IDX_W'(1);
            steps_next = steps + CNT_W'(1);
            if (pr.stop_full) begin
              state_next = S_IDLE;
              done_next = 1'b1;
              status_next = ST_FULL;
              total_next = count;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= SLOTS_CNT) else $error("stored count beyond table size");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_CLEARED |-> entry_total == '0)
    else $error("clear result with nonzero total");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    done_next && status_next != ST_INSERTED && state != S_SWEEP |=> $stable(count))
    else $error("count moved on a rejected insert");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy || state == S_READ)
    else $error("result while sequencer still working");

endmodule
`default_nettype wire

// ----- src/rhks_ram.sv -----
// Single-port-write, registered-read RAM for the slot table.
`default_nettype none
module rhks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/rhks_probe.sv -----
// Probe evaluation: classifies one slot read against the current candidate.
`default_nettype none
module rhks_probe import rhks_pkg::*; (
  input  wire slot_t             rd,
  input  wire logic [HASH_W-1:0] walk_hash,
  input  wire logic [LEN_W-1:0]  walk_len,
  input  wire logic [DIST_W-1:0] walk_hops,
  input  wire logic [CNT_W-1:0]  steps,
  output probe_t                 res
);

  logic [DIST_W-1:0] hops_adv;
  logic [CNT_W-1:0]  steps_inc;
  logic              last_step;

  always_comb begin
    hops_adv = walk_hops + DIST_W'(1);
    steps_inc = steps + CNT_W'(1);
    last_step = (steps_inc == SLOTS_CNT);
    res.act = ACT_ADVANCE;
    res.stop_full = 1'b0;
    res.hops_next = hops_adv;
    priority if (rd.hops == DIST_EMPTY) begin
      res.act = ACT_EMPTY;
    end else if (rd.hash == walk_hash && rd.len == walk_len) begin
      res.act = ACT_MATCH;
    end else if (rd.hops < walk_hops) begin
      res.act = ACT_SWAP;
      res.hops_next = rd.hops + DIST_W'(1);
      res.stop_full = last_step;
    end else begin
      res.act = ACT_ADVANCE;
      res.stop_full = last_step || (hops_adv == DIST_EMPTY);
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the Robin Hood key set insert block: directed and random traffic.
`timescale 1ns / 1ps
module tb_top;
  import rhks_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd = 1'b0;
  logic [HASH_W-1:0] key_hash = '0;
  logic [LEN_W-1:0]  key_length = '0;
  logic              done;
  logic [1:0]        status;
  logic [CNT_W-1:0]  entry_total;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  robin_hood_key_set_insert dut (.*);

  always #2 clk = ~clk;

  typedef struct {
    status_t          st;
    logic [CNT_W-1:0] total;
  } outcome_t;

  // shadow of the table
  logic [HASH_W-1:0] sh_hash [SLOTS];
  logic [LEN_W-1:0]  sh_len  [SLOTS];
  logic [DIST_W-1:0] sh_dist [SLOTS];
  int unsigned       sh_count;
  logic [CNT_W-1:0]  sh_limit;

  outcome_t          pending [$];
  int                errors = 0;
  int                outcomes_seen = 0;
  int                idle_pct = 0;
  int                n_ins = 0, n_dup = 0, n_full = 0, n_clr = 0;
  logic [HASH_W-1:0] recent_hash [$];
  logic [LEN_W-1:0]  recent_len  [$];

  function automatic status_t predict_insert(logic [HASH_W-1:0] h, logic [LEN_W-1:0] l);
    int unsigned       lim;
    int unsigned       idx;
    int unsigned       hops;
    int unsigned       d;
    logic [HASH_W-1:0] ch, th;
    logic [LEN_W-1:0]  cl, tl;
    logic [HASH_W-1:0] bh [SLOTS];
    logic [LEN_W-1:0]  bl [SLOTS];
    logic [DIST_W-1:0] bd [SLOTS];
    lim = sh_limit;
    if (lim == 0) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    if (sh_count + 1 > lim) return ST_FULL;
    bh = sh_hash; bl = sh_len; bd = sh_dist;
    idx = h % SLOTS;
    hops = 0; ch = h; cl = l;
    for (int s = 0; s < SLOTS; s++) begin
      d = bd[idx];
      if (d == DIST_EMPTY) begin
        bh[idx] = ch; bl[idx] = cl; bd[idx] = DIST_W'(hops);
        sh_hash = bh; sh_len = bl; sh_dist = bd;
        sh_count++;
        return ST_INSERTED;
      end
      if (bh[idx] == ch && bl[idx] == cl) return ST_DUPLICATE;
      if (d < hops) begin
        th = bh[idx]; tl = bl[idx];
        bh[idx] = ch; bl[idx] = cl; bd[idx] = DIST_W'(hops);
        ch = th; cl = tl;
        hops = d + 1;
        idx = (idx + 1) % SLOTS;
        continue;
      end
      hops++;
      idx = (idx + 1) % SLOTS;
      if (hops >= DIST_EMPTY) return ST_FULL;
    end
    return ST_FULL;
  endfunction

  function automatic void predict_item(logic c, logic [HASH_W-1:0] h, logic [LEN_W-1:0] l);
    outcome_t o;
    if (c == 1'(CMD_CLEAR)) begin
      for (int i = 0; i < SLOTS; i++) sh_dist[i] = DIST_EMPTY;
      sh_count = 0;
      o.st = ST_CLEARED;
    end else begin
      o.st = predict_insert(h, l);
    end
    o.total = CNT_W'(sh_count);
    pending.push_back(o);
  endfunction

  task automatic send_item(logic c, logic [HASH_W-1:0] h, logic [LEN_W-1:0] l);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    key_hash <= h;
    key_length <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(c, h, l);
    if (c != 1'(CMD_CLEAR) && recent_hash.size() < 64) begin
      recent_hash.push_back(h);
      recent_len.push_back(l);
    end
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard = 0;
    while (pending.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * REG_LOAD_LIMIT); pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sh_limit = CNT_W'(v);
  endtask

  task automatic send_clear();
    send_item(1'(CMD_CLEAR), $urandom(), $urandom());
  endtask

  task automatic send_random_key(int unsigned reuse_pct, int unsigned home_span);
    logic [HASH_W-1:0] h;
    logic [LEN_W-1:0]  l;
    int                k;
    if (recent_hash.size() > 0 && $urandom_range(99) < reuse_pct) begin
      k = $urandom_range(recent_hash.size() - 1);
      h = recent_hash[k];
      l = recent_len[k];
      if ($urandom_range(3) == 0) l = l ^ (32'h1 << $urandom_range(31));
    end else begin
      h = {$urandom(), $urandom()};
      if (home_span != 0) h[IDX_W-1:0] = IDX_W'($urandom_range(home_span - 1));
      l = ($urandom_range(3) == 0) ? $urandom() : LEN_W'($urandom_range(40));
    end
    send_item(1'(CMD_INSERT), h, l);
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      outcomes_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer status=%0d total=%0d", $time, status, entry_total);
        errors++;
      end else begin
        e = pending.pop_front();
        case (status_t'(status))
          ST_INSERTED:  n_ins++;
          ST_DUPLICATE: n_dup++;
          ST_FULL:      n_full++;
          default:      n_clr++;
        endcase
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (entry_total !== e.total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time, e.total, entry_total);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(1'(CMD_INSERT), '0, '0);
    send_item(1'(CMD_INSERT), '0, '0);
    send_item(1'(CMD_INSERT), '1, '1);
    send_item(1'(CMD_INSERT), '1, '1);
    send_item(1'(CMD_INSERT), '1, '0);
    send_item(1'(CMD_INSERT), 64'h0, 32'h5);
    // cluster on one home to force swaps
    for (int i = 0; i < 5; i++) send_item(1'(CMD_INSERT), 64'h400 * i + 3, 32'(i));
    send_item(1'(CMD_INSERT), 64'h4, 32'h7);
    send_item(1'(CMD_INSERT), 64'h1403, 32'd1);
    send_item(1'(CMD_INSERT), 64'h403, 32'd1);
    send_clear();
    send_item(1'(CMD_INSERT), 64'h403, 32'd1);
    write_limit(32'd0);
    send_item(1'(CMD_INSERT), 64'h55, 32'd2);
    send_item(1'(CMD_INSERT), 64'h403, 32'd1);
    send_clear();
    write_limit(32'd2);
    for (int i = 0; i < 3; i++) send_item(1'(CMD_INSERT), 64'h10 + i, 32'd9);
    send_clear();
    write_limit(32'd870);
  endtask

  // many keys on one home: probe distance runs out
  task automatic test_long_probe();
    write_limit(32'd1024);
    for (int i = 0; i < 262; i++)
      send_item(1'(CMD_INSERT), {$urandom(), 22'($urandom()), 10'd500}, 32'(i));
    drain();
    send_clear();
  endtask

  // insert 120 random keys, past the load limit where it is below that
  task automatic test_fill(logic [31:0] lim);
    write_limit(lim);
    for (int i = 0; i < 120; i++) send_random_key(15, 0);
    send_clear();
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) send_clear();
      else send_random_key(25, ($urandom_range(1) == 0) ? 64 : 0);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_dist[i] = DIST_EMPTY;
      sh_hash[i] = '0;
      sh_len[i] = '0;
    end
    sh_count = 0;
    sh_limit = LIMIT_RESET;
    test_directed();
    test_random(180, 0);
    test_random(100, 46);
    drain();
    test_random(100, 25);
    test_long_probe();
    test_fill(32'd100);
    test_fill(32'd1);
    test_fill(32'h7FF);
    write_limit(32'd870);
    test_random(100, 46);
    drain();
    $display("tb_top: %0d results: %0d inserted, %0d duplicate, %0d full, %0d cleared",
             outcomes_seen, n_ins, n_dup, n_full, n_clr);
    $display("tb_top: load limits 0, 1, 2, 100, 870, 1024, 2047 and a probe-distance overflow");
    if (errors == 0 && pending.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
